// ----- rtl/core/mfi_pkg.sv -----
// Package for the money flow index block: widths, constants and the
// transaction payload types. No dependencies.
`timescale 1ns / 1ps

package mfi_pkg;

  localparam int MaxWindow  = 64;
  localparam int RingAw     = $clog2(MaxWindow);
  localparam int WlWidth    = 7;
  localparam int PriceWidth = 24;
  localparam int SumWidth   = PriceWidth + 2;
  localparam int VolWidth   = 32;
  localparam int FlowWidth  = 58;
  localparam int EntryWidth = FlowWidth + 2;
  localparam int AccWidth   = 64;
  localparam int QuoWidth   = 15;
  localparam int IndexMax   = 25600;
  localparam int ScaleShift = 8;
  localparam int ScaleWidth = AccWidth + 7;
  localparam int CntWidth   = $clog2(QuoWidth);

  localparam logic [WlWidth-1:0] WlReset = WlWidth'(10);

  typedef struct packed {
    logic [PriceWidth-1:0] bar_high;
    logic [PriceWidth-1:0] bar_low;
    logic [PriceWidth-1:0] bar_close;
    logic [VolWidth-1:0]   bar_volume;
  } mfi_in_t;

  typedef struct packed {
    logic [QuoWidth-1:0] flow_index;
    logic                undefined_flag;
  } mfi_out_t;

endpackage

// ----- rtl/core/money_flow_index.sv -----
// Money flow index over a sliding window of price bars, top level.
// Depends on mfi_pkg; holds the flow ring memory and the divider.
`timescale 1ns / 1ps

//  channel | ports                              | transaction
//  --------+------------------------------------+---------------------------
//  input   | in_valid, in_ready, in_data        | one price bar
//  result  | out_valid, out_ready, out_data     | index value and flag
//  config  | cfg_wr_en, cfg_wr_data             | window length write
//
//  First bar after reset or a length write seeds the previous sum. Warm-up
//  bar: MUL, SUB, ADD. Result bar: also TOTAL, SCALE1/2, DIV, FINISH (TOTAL
//  to FINISH if both sums are zero); the restoring divider retires one quotient
//  bit per cycle. in_ready is high only while the sequencer is idle; a finished
//  result waits in the output register, and a later result stalls until it is
//  taken. Reset is synchronous; the ring memory is not cleared and needs no sweep.

module money_flow_index (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mfi_pkg::mfi_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mfi_pkg::mfi_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [mfi_pkg::WlWidth-1:0] cfg_wr_data
);
  import mfi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_SUB    = 9'b000000100,
    S_ADD    = 9'b000001000,
    S_TOTAL  = 9'b000010000,
    S_SCALE1 = 9'b000100000,
    S_SCALE2 = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [WlWidth-1:0]    wl_r, wl_nxt;
  logic [SumWidth-1:0]   prev_r, prev_nxt;
  logic [RingAw-1:0]     pos_r, pos_nxt;
  logic [WlWidth-1:0]    bars_r, bars_nxt;
  logic [AccWidth-1:0]   psum_r, psum_nxt;
  logic [AccWidth-1:0]   nsum_r, nsum_nxt;
  logic [SumWidth-1:0]   sum_r, sum_nxt;
  logic [VolWidth-1:0]   vol_r, vol_nxt;
  logic [FlowWidth-1:0]  flow_r, flow_nxt;
  logic                  rise_r, rise_nxt;
  logic                  fall_r, fall_nxt;
  logic [AccWidth-1:0]   tot_r, tot_nxt;
  logic [ScaleWidth-1:0] n_r, n_nxt;
  logic [AccWidth-1:0]   rem_r, rem_nxt;
  logic [QuoWidth-1:0]   low_r, low_nxt;
  logic [QuoWidth-1:0]   quo_r, quo_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic                  undef_r, undef_nxt;
  logic                  out_valid_r, out_valid_nxt;
  mfi_out_t              out_data_r, out_data_nxt;

  logic [EntryWidth-1:0] ring_mem [MaxWindow];
  logic [EntryWidth-1:0] old_r;
  logic                  ring_we;

  logic [SumWidth-1:0]   in_sum;
  logic [FlowWidth-1:0]  prod;
  logic [ScaleWidth-1:0] n_full;
  logic [AccWidth:0]     trial;
  logic [AccWidth:0]     tot_ext;
  logic [WlWidth-1:0]    wl_clamp;
  logic [WlWidth-1:0]    pos_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_sum  = SumWidth'(in_data.bar_high) + SumWidth'(in_data.bar_low)
                 + SumWidth'(in_data.bar_close);
  assign prod    = sum_r * vol_r;
  assign n_full  = n_r + (ScaleWidth'(psum_r) << 2);
  assign trial   = {rem_r, low_r[QuoWidth-1]};
  assign tot_ext = {1'b0, tot_r};
  assign pos_inc = WlWidth'(pos_r) + WlWidth'(1);
  assign ring_we = (state_r == S_ADD);

  always_comb begin
    wl_clamp = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      wl_clamp = WlWidth'(1);
    end else if (cfg_wr_data > WlWidth'(MaxWindow)) begin
      wl_clamp = WlWidth'(MaxWindow);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    bars_nxt      = bars_r;
    psum_nxt      = psum_r;
    nsum_nxt      = nsum_r;
    sum_nxt       = sum_r;
    vol_nxt       = vol_r;
    flow_nxt      = flow_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    tot_nxt       = tot_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    undef_nxt     = undef_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sum_nxt = in_sum;
          vol_nxt = in_data.bar_volume;
          if (bars_r == '0) begin
            prev_nxt = in_sum;
            bars_nxt = WlWidth'(1);
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        flow_nxt  = prod;
        rise_nxt  = sum_r > prev_r;
        fall_nxt  = sum_r < prev_r;
        prev_nxt  = sum_r;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        if (bars_r > wl_r) begin
          if (old_r[FlowWidth]) begin
            psum_nxt = psum_r - AccWidth'(old_r[FlowWidth-1:0]);
          end
          if (old_r[FlowWidth+1]) begin
            nsum_nxt = nsum_r - AccWidth'(old_r[FlowWidth-1:0]);
          end
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (rise_r) begin
          psum_nxt = psum_r + AccWidth'(flow_r);
        end
        if (fall_r) begin
          nsum_nxt = nsum_r + AccWidth'(flow_r);
        end
        pos_nxt = (pos_inc >= wl_r) ? '0 : pos_inc[RingAw-1:0];
        if (bars_r <= wl_r) begin
          bars_nxt = bars_r + WlWidth'(1);
        end
        state_nxt = (bars_r >= wl_r) ? S_TOTAL : S_IDLE;
      end
      S_TOTAL: begin
        tot_nxt = psum_r + nsum_r;
        if ((psum_r + nsum_r) == '0) begin
          undef_nxt = 1'b1;
          quo_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          undef_nxt = 1'b0;
          state_nxt = S_SCALE1;
        end
      end
      S_SCALE1: begin
        n_nxt     = (ScaleWidth'(psum_r) << 6) + (ScaleWidth'(psum_r) << 5);
        state_nxt = S_SCALE2;
      end
      S_SCALE2: begin
        rem_nxt   = n_full[ScaleWidth-1:QuoWidth-ScaleShift];
        low_nxt   = {n_full[QuoWidth-ScaleShift-1:0], ScaleShift'(0)};
        quo_nxt   = '0;
        cnt_nxt   = CntWidth'(QuoWidth - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (trial >= tot_ext) begin
          rem_nxt = AccWidth'(trial - tot_ext);
          quo_nxt = {quo_r[QuoWidth-2:0], 1'b1};
        end else begin
          rem_nxt = trial[AccWidth-1:0];
          quo_nxt = {quo_r[QuoWidth-2:0], 1'b0};
        end
        low_nxt = {low_r[QuoWidth-2:0], 1'b0};
        cnt_nxt = cnt_r - CntWidth'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.flow_index     = quo_r;
          out_data_nxt.undefined_flag = undef_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      wl_nxt   = wl_clamp;
      prev_nxt = '0;
      pos_nxt  = '0;
      bars_nxt = '0;
      psum_nxt = '0;
      nsum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WlReset;
      prev_r      <= '0;
      pos_r       <= '0;
      bars_r      <= '0;
      psum_r      <= '0;
      nsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      bars_r      <= bars_nxt;
      psum_r      <= psum_nxt;
      nsum_r      <= nsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    vol_r      <= vol_nxt;
    flow_r     <= flow_nxt;
    rise_r     <= rise_nxt;
    fall_r     <= fall_nxt;
    tot_r      <= tot_nxt;
    n_r        <= n_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    undef_r    <= undef_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      old_r <= ring_mem[pos_r];
    end
    if (ring_we) begin
      ring_mem[pos_r] <= {fall_r, rise_r, flow_r};
    end
  end

endmodule

// ----- rtl/core/mfi_checker.sv -----
// Port-level checks for money_flow_index, attached by bind.
// Depends on mfi_pkg for the payload types and the index ceiling.
`timescale 1ns / 1ps

module mfi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input mfi_pkg::mfi_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input mfi_pkg::mfi_out_t out_data
);
  import mfi_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction dropped or changed while stalled");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.undefined_flag |-> out_data.flow_index == '0)
    else $error("undefined result carries a nonzero index");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.flow_index <= QuoWidth'(IndexMax))
    else $error("index above full scale");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind money_flow_index mfi_checker u_mfi_checker (.*);
